// ===== sv/mm1040_pkg.sv =====
// Shared types and codes for the Montgomery multiplier controller and datapath.
package mm1040_pkg;

	typedef enum logic [1:0] {
		OP_MUL       = 2'd0,
		OP_SQR       = 2'd1,
		OP_SQR_CHAIN = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_MAC,
		ACC_TAKE_T
	} acc_op_t;

	typedef enum logic [1:0] {
		PAIR_XB,
		PAIR_MQ,
		PAIR_TK
	} mul_pair_t;

	typedef enum logic [1:0] {
		SRC_A,
		SRC_B,
		SRC_W
	} src_t;

	typedef struct packed {
		acc_op_t   acc_op;
		mul_pair_t pair;
		logic [1:0] part;
		logic      v_zero;
		logic      cap_b;
		logic      cap_x;
		logic      cap_q;
		logic      carry_clr;
		logic      digit_end;
		logic      v_wr;
		logic      v_top;
		logic      vtop_clr;
		logic      w_wr;
		logic      out_cap;
		logic      out_last;
		logic [4:0] out_idx;
		src_t      y_src;
		logic      x_w;
	} dp_cmd_t;

endpackage

// ===== sv/mm1040_dp.sv =====
// Datapath: operand stores, running product store, shared half-width multiply-accumulate.
module mm1040_dp
	import mm1040_pkg::*;
#(
	parameter int NUM_DIGITS = 20,
	parameter int DIGIT_BITS = 52,
	parameter int IDX_W      = $clog2(NUM_DIGITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_en,
	input  logic [4:0]       digit_index,
	input  logic [51:0]      a_digit,
	input  logic [51:0]      b_digit,
	input  logic [51:0]      m_digit,
	input  logic             cfg_we,
	input  logic [51:0]      mont_factor,
	input  dp_cmd_t          cmd,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	output logic             result_valid,
	output logic [4:0]       out_index,
	output logic [51:0]      result_digit,
	output logic             last_digit
);

	localparam int D     = DIGIT_BITS;
	localparam int H     = (DIGIT_BITS + 1) / 2;
	localparam int ACC_W = 2 * DIGIT_BITS + 2;
	localparam int CAR_W = DIGIT_BITS + 2;

	logic [D-1:0] a_mem [NUM_DIGITS];
	logic [D-1:0] b_mem [NUM_DIGITS];
	logic [D-1:0] m_mem [NUM_DIGITS];
	logic [D-1:0] v_mem [NUM_DIGITS];
	logic [D-1:0] w_mem [NUM_DIGITS];

	logic [D-1:0] a_rd_q, b_rd_q, m_rd_q, v_rd_q, w_rd_q;
	logic [D-1:0] xr_q, br_q, mr_q, qr_q, tr_q, kr_q;
	logic [ACC_W-1:0] acc_q;
	logic [CAR_W-1:0] carry_q;
	logic [1:0]       vtop_q;
	logic [D-1:0]     res_q;
	logic [4:0]       oidx_q;
	logic             olast_q;
	logic             ovalid_q;

	logic [IDX_W-1:0] ld_addr;
	logic             ld_ok;
	logic [D-1:0]     opa, opb, vsel, bsel;
	logic [H-1:0]     mul_a, mul_b;
	logic [2*H-1:0]   prod;
	logic [ACC_W-1:0] prod_ext, mac_term;
	logic [D+2:0]     top_sum;

	assign ld_addr = IDX_W'(digit_index);
	assign ld_ok   = ({27'd0, digit_index} < 32'(NUM_DIGITS));

	always_comb begin
		unique case (cmd.pair)
			PAIR_XB: begin
				opa = xr_q;
				opb = br_q;
			end
			PAIR_MQ: begin
				opa = mr_q;
				opb = qr_q;
			end
			PAIR_TK: begin
				opa = tr_q;
				opb = kr_q;
			end
			default: begin
				opa = xr_q;
				opb = br_q;
			end
		endcase
	end

	assign mul_a    = cmd.part[1] ? H'(opa >> H) : opa[H-1:0];
	assign mul_b    = cmd.part[0] ? H'(opb >> H) : opb[H-1:0];
	assign prod     = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod);

	always_comb begin
		unique case (cmd.part)
			2'b00:   mac_term = prod_ext;
			2'b11:   mac_term = prod_ext << (2 * H);
			default: mac_term = prod_ext << H;
		endcase
	end

	assign vsel    = cmd.v_zero ? '0 : v_rd_q;
	assign top_sum = {1'b0, carry_q} + (D+3)'(vtop_q);

	always_comb begin
		unique case (cmd.y_src)
			SRC_A:   bsel = a_rd_q;
			SRC_B:   bsel = b_rd_q;
			default: bsel = w_rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_en && ld_ok) begin
			a_mem[ld_addr] <= a_digit[D-1:0];
			b_mem[ld_addr] <= b_digit[D-1:0];
			m_mem[ld_addr] <= m_digit[D-1:0];
		end
		if (cmd.v_wr) begin
			v_mem[wr_addr] <= cmd.v_top ? top_sum[D-1:0] : acc_q[D-1:0];
		end
		if (cmd.w_wr) begin
			w_mem[wr_addr] <= v_rd_q;
		end
		a_rd_q <= a_mem[rd_addr];
		b_rd_q <= b_mem[rd_addr];
		m_rd_q <= m_mem[rd_addr];
		v_rd_q <= v_mem[rd_addr];
		w_rd_q <= w_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_b) begin
			br_q <= bsel;
		end
		if (cmd.cap_x) begin
			xr_q <= cmd.x_w ? w_rd_q : a_rd_q;
			mr_q <= m_rd_q;
		end
		if (cmd.cap_q) begin
			qr_q <= acc_q[D-1:0];
		end
		unique case (cmd.acc_op)
			ACC_HOLD: ;
			ACC_LOAD: acc_q <= ACC_W'(vsel) + ACC_W'(carry_q);
			ACC_MAC:  acc_q <= acc_q + mac_term;
			ACC_TAKE_T: begin
				tr_q  <= acc_q[D-1:0];
				acc_q <= '0;
			end
			default: ;
		endcase
		if (cmd.carry_clr) begin
			carry_q <= '0;
		end else if (cmd.digit_end) begin
			carry_q <= CAR_W'(acc_q >> D);
		end
		if (cmd.out_cap) begin
			res_q   <= v_rd_q;
			oidx_q  <= cmd.out_idx;
			olast_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q     <= '0;
			vtop_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kr_q <= mont_factor[D-1:0];
			end
			if (cmd.vtop_clr) begin
				vtop_q <= '0;
			end else if (cmd.v_top) begin
				vtop_q <= top_sum[D+1:D];
			end
			ovalid_q <= cmd.out_cap;
		end
	end

	assign result_valid = ovalid_q;
	assign out_index    = oidx_q;
	assign result_digit = 52'(res_q);
	assign last_digit   = ovalid_q & olast_q;

endmodule

// ===== sv/mm1040_ctrl.sv =====
// Controller: sequences rounds, digit steps, pass copies and the result beats.
module mm1040_ctrl
	import mm1040_pkg::*;
#(
	parameter int NUM_DIGITS = 20,
	parameter int SQUARINGS  = 5,
	parameter int IDX_W      = $clog2(NUM_DIGITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       op,
	input  logic             last_load,
	output logic             busy,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr,
	output dp_cmd_t          cmd
);

	localparam int CNT_W = $clog2(NUM_DIGITS + 1);
	localparam int PW    = $clog2(SQUARINGS + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_DIGITS - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_DIGITS);

	typedef enum logic [3:0] {
		S_IDLE, S_PASS, S_RD_B, S_CAP_B, S_Q_LOAD, S_Q_MULB, S_Q_T, S_Q_MULK,
		S_Q_CAP, S_D_LOAD, S_D_MULB, S_D_MULM, S_D_END, S_TOP, S_COPY, S_OUT
	} state_t;

	state_t           state_q;
	logic [1:0]       part_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] rnd_q;
	logic [PW-1:0]    pass_q;
	logic             sq_q;
	logic             xw_q;
	logic [CNT_W-1:0] j_dec;
	logic [CNT_W-1:0] j_inc;

	assign busy  = (state_q != S_IDLE);
	assign j_dec = j_q - CNT_W'(1);
	assign j_inc = j_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q  <= '0;
			j_q     <= '0;
			rnd_q   <= '0;
			pass_q  <= '0;
			sq_q    <= 1'b0;
			xw_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && last_load) begin
						sq_q   <= (op == OP_SQR) || (op == OP_SQR_CHAIN);
						pass_q <= (op == OP_SQR_CHAIN) ? PW'(SQUARINGS - 1) : '0;
						xw_q   <= 1'b0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					rnd_q   <= '0;
					state_q <= S_RD_B;
				end
				S_RD_B:   state_q <= S_CAP_B;
				S_CAP_B:  state_q <= S_Q_LOAD;
				S_Q_LOAD: begin
					part_q  <= '0;
					state_q <= S_Q_MULB;
				end
				S_Q_MULB: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= S_Q_T;
					end
				end
				S_Q_T: state_q <= S_Q_MULK;
				S_Q_MULK: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= S_Q_CAP;
					end
				end
				S_Q_CAP: begin
					j_q     <= '0;
					state_q <= S_D_LOAD;
				end
				S_D_LOAD: begin
					part_q  <= '0;
					state_q <= S_D_MULB;
				end
				S_D_MULB: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= S_D_MULM;
					end
				end
				S_D_MULM: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= S_D_END;
					end
				end
				S_D_END: begin
					j_q <= j_inc;
					state_q <= (j_q == LAST) ? S_TOP : S_D_LOAD;
				end
				S_TOP: begin
					rnd_q <= rnd_q + CNT_W'(1);
					j_q   <= '0;
					if (rnd_q != LAST) begin
						state_q <= S_RD_B;
					end else if (pass_q != '0) begin
						pass_q  <= pass_q - PW'(1);
						state_q <= S_COPY;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_COPY: begin
					j_q <= j_inc;
					if (j_q == FULL) begin
						xw_q    <= 1'b1;
						state_q <= S_PASS;
					end
				end
				S_OUT: begin
					j_q <= j_inc;
					if (j_q == FULL) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.acc_op = ACC_HOLD;
		cmd.pair   = PAIR_XB;
		cmd.part   = part_q;
		cmd.v_zero = (rnd_q == '0);
		cmd.x_w    = xw_q;
		cmd.y_src  = sq_q ? (xw_q ? SRC_W : SRC_A) : SRC_B;
		cmd.out_idx = 5'(j_dec);
		cmd.out_last = (j_q == FULL);
		rd_addr    = '0;
		wr_addr    = j_dec[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: ;
			S_PASS:   cmd.vtop_clr = 1'b1;
			S_RD_B:   rd_addr = rnd_q[IDX_W-1:0];
			S_CAP_B: begin
				cmd.cap_b     = 1'b1;
				cmd.carry_clr = 1'b1;
			end
			S_Q_LOAD: begin
				cmd.acc_op = ACC_LOAD;
				cmd.cap_x  = 1'b1;
			end
			S_Q_MULB: cmd.acc_op = ACC_MAC;
			S_Q_T:    cmd.acc_op = ACC_TAKE_T;
			S_Q_MULK: begin
				cmd.acc_op = ACC_MAC;
				cmd.pair   = PAIR_TK;
			end
			S_Q_CAP:  cmd.cap_q = 1'b1;
			S_D_LOAD: begin
				cmd.acc_op = ACC_LOAD;
				cmd.cap_x  = 1'b1;
			end
			S_D_MULB: cmd.acc_op = ACC_MAC;
			S_D_MULM: begin
				cmd.acc_op = ACC_MAC;
				cmd.pair   = PAIR_MQ;
			end
			S_D_END: begin
				cmd.digit_end = 1'b1;
				cmd.v_wr      = (j_q != '0);
				rd_addr       = (j_q == LAST) ? '0 : j_inc[IDX_W-1:0];
			end
			S_TOP: begin
				cmd.v_wr  = 1'b1;
				cmd.v_top = 1'b1;
				wr_addr   = LAST[IDX_W-1:0];
			end
			S_COPY: begin
				cmd.w_wr = (j_q != '0);
				rd_addr  = (j_q == FULL) ? '0 : j_q[IDX_W-1:0];
			end
			S_OUT: begin
				cmd.out_cap = (j_q != '0);
				rd_addr     = (j_q == FULL) ? '0 : j_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/montgomery_multiplier_1040.sv =====
// Top level of the word-serial almost-Montgomery multiplier.
//
// Usage: load operands one digit per beat on the command channel (start,
// accepted while busy is low). Each beat with digit_index below NUM_DIGITS
// stores a_digit, b_digit and m_digit there; the beat with last_load set
// takes op and starts a run. The mont_factor register is written on its own
// valid/ready channel; ready is high while the block is not busy.
// Each pass does NUM_DIGITS rounds. In each round one shared half-digit
// multiplier builds each digit product from four half-digit partial
// products, two products per digit, and the quotient digit needs two more
// products. The chained squaring op runs SQUARINGS passes with a copy of
// the product into the work store between passes. Results then leave as
// NUM_DIGITS beats, one per cycle, each shown for one cycle with
// result_valid; last_digit marks the final beat. The receiver cannot stall,
// so the block never waits on it.
// Reset clears the controller, the factor register and the output strobe;
// the operand stores keep undefined contents until loaded.
module montgomery_multiplier_1040
	import mm1040_pkg::*;
#(
	parameter int NUM_DIGITS = 20,
	parameter int DIGIT_BITS = 52,
	parameter int SQUARINGS  = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [4:0]  digit_index,
	input  logic [51:0] a_digit,
	input  logic [51:0] b_digit,
	input  logic [51:0] m_digit,
	input  logic        last_load,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [51:0] mont_factor,
	output logic        result_valid,
	output logic [4:0]  out_index,
	output logic [51:0] result_digit,
	output logic        last_digit
);

	localparam int IDX_W = $clog2(NUM_DIGITS);

	dp_cmd_t          cmd;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             load_en;

	assign load_en   = start & ~busy;
	assign cfg_ready = ~busy;

	mm1040_ctrl #(
		.NUM_DIGITS (NUM_DIGITS),
		.SQUARINGS  (SQUARINGS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.last_load (last_load),
		.busy      (busy),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.cmd       (cmd)
	);

	mm1040_dp #(
		.NUM_DIGITS (NUM_DIGITS),
		.DIGIT_BITS (DIGIT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_en      (load_en),
		.digit_index  (digit_index),
		.a_digit      (a_digit),
		.b_digit      (b_digit),
		.m_digit      (m_digit),
		.cfg_we       (cfg_valid & cfg_ready),
		.mont_factor  (mont_factor),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.result_valid (result_valid),
		.out_index    (out_index),
		.result_digit (result_digit),
		.last_digit   (last_digit)
	);

endmodule

// ===== sv/mm1040_chk.sv =====
// Port-level checker for the Montgomery multiplier, bound to the top level.
module mm1040_chk #(
	parameter int NUM_DIGITS = 20
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       last_load,
	input logic       result_valid,
	input logic [4:0] out_index,
	input logic       last_digit
);

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_load |=> busy)
		else $error("run did not start");

	a_beats_consecutive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_digit |=> result_valid && (out_index == $past(out_index) + 5'd1))
		else $error("result beats not consecutive");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_digit |=> !result_valid)
		else $error("beat after last digit");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_digit |-> out_index == 5'(NUM_DIGITS - 1))
		else $error("last digit at wrong index");

endmodule

bind montgomery_multiplier_1040 mm1040_chk #(.NUM_DIGITS(NUM_DIGITS)) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_load    (last_load),
	.result_valid (result_valid),
	.out_index    (out_index),
	.last_digit   (last_digit)
);

// ===== tb/sv/montgomery_multiplier_1040_tb.sv =====
// Testbench for the word-serial almost-Montgomery multiplier: directed and random operand loads.
module montgomery_multiplier_1040_tb;
	import mm1040_pkg::*;

	localparam int NDIG = 20;
	localparam int SQR_PASSES = 5;
	localparam int WATCHDOG_LIMIT = 120000;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [51:0] DIGIT_MAX = {52{1'b1}};

	typedef logic [51:0] digits_t [NDIG];

	typedef struct {
		logic [4:0]  idx;
		logic [51:0] digit;
		logic        last;
	} digit_beat_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [4:0]  digit_index;
	logic [51:0] a_digit;
	logic [51:0] b_digit;
	logic [51:0] m_digit;
	logic        last_load;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [51:0] mont_factor;
	logic        result_valid;
	logic [4:0]  out_index;
	logic [51:0] result_digit;
	logic        last_digit;

	digits_t a_mirror, b_mirror, m_mirror;
	logic [51:0] factor_mirror;
	digit_beat_t product_q [$];
	int errors = 0;
	int beats_sent = 0;
	int runs_started = 0;
	int digits_checked = 0;
	int burst_left = 0;
	bit gaps_on = 1;
	int idle_cycles = 0;

	montgomery_multiplier_1040 dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.digit_index(digit_index), .a_digit(a_digit), .b_digit(b_digit),
		.m_digit(m_digit), .last_load(last_load), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .mont_factor(mont_factor),
		.result_valid(result_valid), .out_index(out_index),
		.result_digit(result_digit), .last_digit(last_digit)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void mont_product(input digits_t x, input digits_t y,
		input digits_t m, input logic [51:0] f, output digits_t r);
		logic [63:0] acc [NDIG];
		logic [63:0] s, low, v, c;
		logic [103:0] p1, p2, t;
		logic [51:0] q;
		for (int j = 0; j < NDIG; j++) acc[j] = '0;
		for (int i = 0; i < NDIG; i++) begin
			p1 = 104'(x[0]) * 104'(y[i]);
			s = acc[0] + 64'(p1[51:0]);
			t = 104'(s[51:0]) * 104'(f);
			q = t[51:0];
			for (int j = 0; j < NDIG; j++) begin
				p1 = 104'(x[j]) * 104'(y[i]);
				p2 = 104'(m[j]) * 104'(q);
				acc[j] = acc[j] + 64'(p1[51:0]) + 64'(p2[51:0]);
			end
			low = acc[0] >> 52;
			for (int j = 0; j + 1 < NDIG; j++) acc[j] = acc[j + 1];
			acc[NDIG - 1] = '0;
			acc[0] = acc[0] + low;
			for (int j = 0; j < NDIG; j++) begin
				p1 = 104'(x[j]) * 104'(y[i]);
				p2 = 104'(m[j]) * 104'(q);
				acc[j] = acc[j] + 64'(p1 >> 52) + 64'(p2 >> 52);
			end
		end
		c = '0;
		for (int j = 0; j < NDIG; j++) begin
			v = acc[j] + c;
			r[j] = v[51:0];
			c = v >> 52;
		end
	endfunction

	task automatic predict_beat(input logic [1:0] bop, input logic [4:0] idx,
		input logic [51:0] a, input logic [51:0] b, input logic [51:0] m, input logic lst);
		digits_t res, work;
		digit_beat_t eb;
		if (idx < NDIG) begin
			a_mirror[idx] = a;
			b_mirror[idx] = b;
			m_mirror[idx] = m;
		end
		if (lst) begin
			runs_started++;
			if (bop == OP_SQR) begin
				mont_product(a_mirror, a_mirror, m_mirror, factor_mirror, res);
			end else if (bop == OP_SQR_CHAIN) begin
				mont_product(a_mirror, a_mirror, m_mirror, factor_mirror, res);
				for (int k = 1; k < SQR_PASSES; k++) begin
					work = res;
					mont_product(work, work, m_mirror, factor_mirror, res);
				end
			end else begin
				mont_product(a_mirror, b_mirror, m_mirror, factor_mirror, res);
			end
			for (int j = 0; j < NDIG; j++) begin
				eb.idx = 5'(j);
				eb.digit = res[j];
				eb.last = (j == NDIG - 1);
				product_q.push_back(eb);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h, expected %h", what, got, want);
	endtask

	always @(posedge clk) begin
		digit_beat_t eb;
		if (arst_n && result_valid) begin
			if (product_q.size() == 0) begin
				report_mismatch("unexpected digit", 64'(result_digit), 64'(0));
			end else begin
				eb = product_q.pop_front();
				digits_checked++;
				if (out_index !== eb.idx)
					report_mismatch("out_index", 64'(out_index), 64'(eb.idx));
				if (result_digit !== eb.digit)
					report_mismatch("result_digit", 64'(result_digit), 64'(eb.digit));
				if (last_digit !== eb.last)
					report_mismatch("last_digit", 64'(last_digit), 64'(eb.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d digits pending", product_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [51:0] rand_digit();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return '0;
		if (pick == 1) return DIGIT_MAX;
		return 52'({$urandom(), $urandom()});
	endfunction

	task automatic send_beat(input logic [1:0] bop, input logic [4:0] idx,
		input logic [51:0] a, input logic [51:0] b, input logic [51:0] m, input logic lst);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 8);
			repeat (gap) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		start <= 1'b1;
		op <= bop;
		digit_index <= idx;
		a_digit <= a;
		b_digit <= b;
		m_digit <= m;
		last_load <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		beats_sent++;
		predict_beat(bop, idx, a, b, m, lst);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (product_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_factor(input logic [51:0] f);
		drain_results();
		cfg_valid <= 1'b1;
		mont_factor <= f;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		factor_mirror = f;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_extreme_operands();
		write_factor(DIGIT_MAX);
		for (int j = 0; j < NDIG; j++)
			send_beat(OP_MUL, 5'(j), DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, j == NDIG - 1);
		send_beat(OP_SQR, 5'd0, '0, DIGIT_MAX, 52'd1, 1'b1);
	endtask

	task automatic test_ops_and_corners();
		write_factor('0);
		send_beat(OP_MUL, 5'd19, '0, '0, DIGIT_MAX, 1'b1);
		write_factor(52'h5_A5A5_A5A5_A5A5);
		send_beat(OP_SQR_CHAIN, 5'd3, 52'h1234_5678_9ABC, '0, DIGIT_MAX, 1'b1);
		send_beat(OP_SPARE, 5'd7, DIGIT_MAX, 52'd3, DIGIT_MAX, 1'b1);
		send_beat(OP_MUL, 5'd31, '0, '0, '0, 1'b1);
		send_beat(OP_SQR, 5'd5, 52'd7, 52'd9, DIGIT_MAX, 1'b0);
		send_beat(OP_SQR, 5'd25, DIGIT_MAX, DIGIT_MAX, '0, 1'b1);
	endtask

	task automatic test_random_runs(input int beat_budget);
		int target, cnt, pick;
		logic [1:0] bop;
		logic [4:0] idx;
		target = beats_sent + beat_budget;
		while (beats_sent < target) begin
			cnt = $urandom_range(1, 6);
			if ($urandom_range(0, 7) == 0) cnt = NDIG;
			pick = $urandom_range(0, 19);
			bop = (pick < 9) ? OP_MUL : (pick < 15) ? OP_SQR :
				(pick < 17) ? OP_SQR_CHAIN : OP_SPARE;
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < cnt; k++) begin
				if (cnt == NDIG) idx = 5'(k);
				else if ($urandom_range(0, 9) == 0) idx = 5'($urandom_range(NDIG, 31));
				else idx = 5'($urandom_range(0, NDIG - 1));
				send_beat((k == cnt - 1) ? bop : 2'($urandom_range(0, 3)), idx,
					rand_digit(), rand_digit(), rand_digit(), k == cnt - 1);
			end
		end
		gaps_on = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_MUL;
		digit_index = '0;
		a_digit = '0;
		b_digit = '0;
		m_digit = '0;
		last_load = 1'b0;
		cfg_valid = 1'b0;
		mont_factor = '0;
		factor_mirror = '0;
		for (int j = 0; j < NDIG; j++) begin
			a_mirror[j] = '0;
			b_mirror[j] = '0;
			m_mirror[j] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extreme_operands();
		test_ops_and_corners();
		write_factor(52'({$urandom(), $urandom()}));
		test_random_runs(25);
		write_factor(DIGIT_MAX);
		test_random_runs(25);
		write_factor('0);
		test_random_runs(15);
		write_factor(52'({$urandom(), $urandom()}));
		test_random_runs(25);
		drain_results();
		repeat (40) @(negedge clk);
		$display("covered %0d load beats, %0d runs, %0d result digits checked",
			beats_sent, runs_started, digits_checked);
		$display("ops: multiply, square, chained square, spare code; factor 0, max, random");
		if (errors == 0 && product_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d digits pending", errors, product_q.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
